// File: hw/rtl/a64dp_pkg.sv
// a64dp_pkg: types and constants of the A64 data-processing (register) execute block.
// No dependencies; imported by the ALU, the register file and the top level.

package a64dp_pkg;

  localparam int unsigned RegCount = 31;
  localparam logic [4:0]  ZeroReg  = 5'd31;

  // register file read ports
  localparam int unsigned PortN   = 0;
  localparam int unsigned PortM   = 1;
  localparam int unsigned PortA   = 2;
  localparam int unsigned RdPorts = 3;

  // logical opc codes
  localparam logic [1:0] LogicAnd  = 2'd0;
  localparam logic [1:0] LogicOrr  = 2'd1;
  localparam logic [1:0] LogicEor  = 2'd2;
  localparam logic [1:0] LogicAnds = 2'd3;

  // add/sub opc bits
  localparam int unsigned OpcSetBit = 0;
  localparam int unsigned OpcSubBit = 1;

  typedef enum logic [1:0] {
    ShLsl = 2'd0,
    ShLsr = 2'd1,
    ShAsr = 2'd2,
    ShRor = 2'd3
  } shift_e;

  // {M, bit24}
  typedef enum logic [1:0] {
    GrpLogic  = 2'b00,
    GrpAddSub = 2'b01,
    GrpNone   = 2'b10,
    GrpMul    = 2'b11
  } group_e;

  typedef struct packed {
    logic       sf;
    logic [1:0] opc;
    logic       m;
    logic [2:0] fixed;
    logic       b24;
    shift_e     shift;
    logic       n;
    logic [4:0] rm;
    logic [5:0] imm6;   // Ra in [4:0], o0 in [5] for multiply
    logic [4:0] rn;
    logic [4:0] rd;
  } insn_t;

  typedef struct packed {
    logic        executed;
    logic        we;
    logic        is_mul;
    logic        sub;
    logic        sf;
    logic [3:0]  flags;
    logic [63:0] res;    // final result, or the accumulator for multiply
    logic [63:0] pll;
    logic [31:0] plh;
    logic [31:0] phl;
  } alu_out_t;

  typedef struct packed {
    logic        we;
    logic [4:0]  addr;
    logic [63:0] data;
  } rf_wr_t;

endpackage

// File: hw/rtl/a64dp_if.sv
// a64dp_insn_if / a64dp_res_if: valid/ready channels for instruction words and results.
// Standalone; used by the top level a64_register_data_processing.

interface a64dp_insn_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction_word;

  modport source (output valid, output instruction_word, input ready);
  modport sink   (input valid, input instruction_word, output ready);
endinterface

interface a64dp_res_if;
  logic        valid;
  logic        ready;
  logic        executed;
  logic        write_enable;
  logic [4:0]  dest_index;
  logic [63:0] write_value;
  logic        flag_n;
  logic        flag_z;
  logic        flag_c;
  logic        flag_v;

  modport source (
    output valid, output executed, output write_enable, output dest_index,
    output write_value, output flag_n, output flag_z, output flag_c, output flag_v,
    input ready
  );
  modport sink (
    input valid, input executed, input write_enable, input dest_index,
    input write_value, input flag_n, input flag_z, input flag_c, input flag_v,
    output ready
  );
endinterface

// File: hw/rtl/a64dp_alu.sv
// a64dp_alu: decode and first execute stage: shifter, logic unit, adder, flags, partial products.
// Depends on a64dp_pkg.

module a64dp_alu
  import a64dp_pkg::*;
(
  input  logic [31:0] insn_i,
  input  logic [63:0] op_n_i,
  input  logic [63:0] op_m_i,
  input  logic [63:0] op_a_i,
  input  logic [3:0]  flags_i,
  output alu_out_t    alu_o
);

  function automatic logic [63:0] shift64(input logic [63:0] v, input shift_e code,
                                          input logic [5:0] amt);
    logic [63:0] r;
    case (code)
      ShLsl:   r = v << amt;
      ShLsr:   r = v >> amt;
      ShAsr:   r = $unsigned($signed(v) >>> amt);
      ShRor:   r = (v >> amt) | (v << (7'd64 - {1'b0, amt}));
      default: r = v;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] shift32(input logic [31:0] v, input shift_e code,
                                          input logic [4:0] amt);
    logic [31:0] r;
    case (code)
      ShLsl:   r = v << amt;
      ShLsr:   r = v >> amt;
      ShAsr:   r = $unsigned($signed(v) >>> amt);
      ShRor:   r = (v >> amt) | (v << (6'd32 - {1'b0, amt}));
      default: r = v;
    endcase
    return r;
  endfunction

  insn_t       f;
  group_e      grp;
  logic [63:0] wmask, a, b, acc;
  logic [5:0]  amt;
  logic [63:0] sh, lop, lres, op2, bop, ares;
  logic        cin;
  logic [64:0] sum64;
  logic [32:0] sum32;
  logic        an, az, ac, av, ln, lz;
  logic [63:0] pll;
  logic [31:0] plh, phl;

  always_comb begin
    f     = insn_t'(insn_i);
    grp   = group_e'({f.m, f.b24});
    wmask = f.sf ? {64{1'b1}} : {32'b0, {32{1'b1}}};
    a     = op_n_i & wmask;
    b     = op_m_i & wmask;
    acc   = op_a_i & wmask;
    amt   = f.sf ? f.imm6 : {1'b0, f.imm6[4:0]};
    sh    = f.sf ? shift64(b, f.shift, amt) : {32'b0, shift32(b[31:0], f.shift, amt[4:0])};

    // logical
    lop = f.n ? (~sh & wmask) : sh;
    case (f.opc) inside
      LogicAnd, LogicAnds: lres = a & lop;
      LogicOrr:            lres = a | lop;
      LogicEor:            lres = a ^ lop;
      default:             lres = a & lop;
    endcase
    ln = f.sf ? lres[63] : lres[31];
    lz = (lres == 64'd0);

    // add/sub; shift code ROR means no shift here
    op2   = (f.shift == ShRor) ? b : sh;
    bop   = f.opc[OpcSubBit] ? (~op2 & wmask) : op2;
    cin   = f.opc[OpcSubBit];
    sum64 = {1'b0, a} + {1'b0, bop} + {64'b0, cin};
    sum32 = {1'b0, a[31:0]} + {1'b0, bop[31:0]} + {32'b0, cin};
    if (f.sf) begin
      ares = sum64[63:0];
      ac   = sum64[64];
      av   = ~(a[63] ^ bop[63]) & (a[63] ^ ares[63]);
      an   = ares[63];
    end else begin
      ares = {32'b0, sum32[31:0]};
      ac   = sum32[32];
      av   = ~(a[31] ^ bop[31]) & (a[31] ^ ares[31]);
      an   = ares[31];
    end
    az = (ares == 64'd0);

    // partial products, low 64 bits of the full product only
    pll = {32'b0, a[31:0]} * {32'b0, b[31:0]};
    plh = a[31:0] * b[63:32];
    phl = a[63:32] * b[31:0];

    alu_o          = '0;
    alu_o.executed = 1'b1;
    alu_o.flags    = flags_i;
    alu_o.sf       = f.sf;
    alu_o.sub      = f.imm6[5];
    alu_o.pll      = pll;
    alu_o.plh      = plh;
    alu_o.phl      = phl;
    unique case (grp)
      GrpLogic: begin
        alu_o.res = lres;
        if (f.opc == LogicAnds) alu_o.flags = {ln, lz, 2'b00};
      end
      GrpAddSub: begin
        alu_o.res = ares;
        if (f.opc[OpcSetBit]) alu_o.flags = {an, az, ac, av};
      end
      GrpMul: begin
        alu_o.is_mul = 1'b1;
        alu_o.res    = acc;
      end
      GrpNone: alu_o.executed = 1'b0;
      default: alu_o.executed = 1'b0;
    endcase
    alu_o.we = alu_o.executed & (f.rd != ZeroReg);
  end

endmodule

// File: hw/rtl/a64dp_regfile.sv
// a64dp_regfile: 31 x 64 general registers, two memory copies, three registered read ports.
// Read data tracks writes that land while it is held. Depends on a64dp_pkg.

module a64dp_regfile
  import a64dp_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      rd_en_i,
  input  logic [RdPorts-1:0][4:0]   raddr_i,
  input  rf_wr_t                    wr_i,
  output logic [RdPorts-1:0][63:0]  rdata_o
);

  logic [63:0] mem_a_q [RegCount];  // read by ports N and M
  logic [63:0] mem_b_q [RegCount];  // read by port A
  logic [RegCount-1:0] valid_q;

  logic [RdPorts-1:0][63:0] memd_q;
  logic [RdPorts-1:0][63:0] hitd_q;
  logic [RdPorts-1:0][4:0]  addr_q;
  logic [RdPorts-1:0]       hit_q;
  logic [RdPorts-1:0]       vld_q;
  logic [RdPorts-1:0]       wr_match;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_a_q[wr_i.addr] <= wr_i.data;
      mem_b_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      memd_q[PortN] <= mem_a_q[raddr_i[PortN]];
      memd_q[PortM] <= mem_a_q[raddr_i[PortM]];
      memd_q[PortA] <= mem_b_q[raddr_i[PortA]];
    end
  end

  always_comb begin
    for (int p = 0; p < RdPorts; p++) begin
      wr_match[p] = wr_i.we && (wr_i.addr == addr_q[p]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int p = 0; p < RdPorts; p++) begin
      if (rd_en_i || wr_match[p]) hitd_q[p] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      addr_q  <= '0;
      hit_q   <= '0;
      vld_q   <= '0;
    end else begin
      if (wr_i.we) valid_q[wr_i.addr] <= 1'b1;
      for (int p = 0; p < RdPorts; p++) begin
        if (rd_en_i) begin
          addr_q[p] <= raddr_i[p];
          hit_q[p]  <= wr_i.we && (wr_i.addr == raddr_i[p]);
          vld_q[p]  <= (raddr_i[p] != ZeroReg) && valid_q[raddr_i[p]];
        end else if (wr_match[p]) begin
          hit_q[p] <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    for (int p = 0; p < RdPorts; p++) begin
      if (addr_q[p] == ZeroReg) rdata_o[p] = 64'd0;
      else if (hit_q[p])        rdata_o[p] = hitd_q[p];
      else if (vld_q[p])        rdata_o[p] = memd_q[p];
      else                      rdata_o[p] = 64'd0;
    end
  end

endmodule

// File: hw/rtl/a64_register_data_processing.sv
// a64_register_data_processing: top level of the A64 data-processing (register) execute block.
// Depends on a64dp_pkg, a64dp_if, a64dp_alu and a64dp_regfile.
//
// Executes one A64 logical, add/sub (shifted register) or MADD/MSUB word per cycle when not
// stalled, against 31 general registers and NZCV, returning one result word per instruction
// word. A word is read from the register file as it is accepted, runs the shifter/adder/logic
// and the 32x32 partial products in the first stage, and finishes the multiply-accumulate in
// the second stage, when the register file is written and the result register loads and offers it.
// Throughput is one word per cycle unless res_o.ready holds the result register or a hazard
// stalls; a word that reads (Rn, Rm or Ra) the destination of a MADD/MSUB directly ahead of
// it waits in the first stage until that value exists, at the end of the second stage.
// ALU results are forwarded. Reset clears the register file valid bits and the flags at once;
// there is no clearing pass.

module a64_register_data_processing
  import a64dp_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  a64dp_insn_if.sink insn_i,
  a64dp_res_if.source res_o
);

  // stage 1
  logic        s1_v_q;
  logic [31:0] s1_insn_q;
  insn_t       s1_f, in_f;

  // stage 2
  logic        s2_v_q, s2_exec_q, s2_we_q, s2_mul_q, s2_sub_q, s2_sf_q;
  logic [4:0]  s2_rd_q;
  logic [3:0]  s2_flags_q;
  logic [63:0] s2_res_q, s2_pll_q;
  logic [31:0] s2_plh_q, s2_phl_q;

  // result register
  logic        out_v_q, out_exec_q, out_we_q;
  logic [4:0]  out_rd_q;
  logic [63:0] out_val_q;
  logic [3:0]  out_flags_q;

  logic [3:0]  flags_q;

  logic                     accept, s1_go, out_load, mul_haz;
  logic [RdPorts-1:0][4:0]  raddr, src1;
  logic [RdPorts-1:0][63:0] rdata, opnd;
  logic [RdPorts-1:0]       fwd_hit;
  alu_out_t                 alu;
  rf_wr_t                   rf_wr;
  logic [31:0]              prod_hi;
  logic [63:0]              prod, macc, wdata;

  assign in_f = insn_t'(insn_i.instruction_word);
  assign s1_f = insn_t'(s1_insn_q);

  always_comb begin
    raddr[PortN] = in_f.rn;
    raddr[PortM] = in_f.rm;
    raddr[PortA] = in_f.imm6[4:0];
    src1[PortN]  = s1_f.rn;
    src1[PortM]  = s1_f.rm;
    src1[PortA]  = s1_f.imm6[4:0];
    for (int p = 0; p < RdPorts; p++) begin
      fwd_hit[p] = s2_v_q && s2_we_q && (s2_rd_q == src1[p]);
      opnd[p]    = (fwd_hit[p] && !s2_mul_q) ? s2_res_q : rdata[p];
    end
    mul_haz = s2_mul_q && (|fwd_hit);
  end

  // handshake
  assign out_load     = s2_v_q && (!out_v_q || res_o.ready);
  assign s1_go        = s1_v_q && !mul_haz && (!s2_v_q || out_load);
  assign insn_i.ready = !s1_v_q || s1_go;
  assign accept       = insn_i.valid && insn_i.ready;

  a64dp_regfile u_rf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_en_i (accept),
    .raddr_i (raddr),
    .wr_i    (rf_wr),
    .rdata_o (rdata)
  );

  a64dp_alu u_alu (
    .insn_i  (s1_insn_q),
    .op_n_i  (opnd[PortN]),
    .op_m_i  (opnd[PortM]),
    .op_a_i  (opnd[PortA]),
    .flags_i (flags_q),
    .alu_o   (alu)
  );

  // multiply-accumulate completion
  always_comb begin
    prod_hi = s2_pll_q[63:32] + s2_plh_q + s2_phl_q;
    prod    = {prod_hi, s2_pll_q[31:0]};
    macc    = s2_sub_q ? (s2_res_q - prod) : (s2_res_q + prod);
    if (!s2_sf_q) macc[63:32] = 32'd0;
    wdata   = s2_mul_q ? macc : s2_res_q;

    rf_wr.we   = out_load && s2_we_q;
    rf_wr.addr = s2_rd_q;
    rf_wr.data = wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      flags_q <= 4'd0;
    end else begin
      if (accept)     s1_v_q <= 1'b1;
      else if (s1_go) s1_v_q <= 1'b0;

      if (s1_go)         s2_v_q <= 1'b1;
      else if (out_load) s2_v_q <= 1'b0;

      if (out_load)          out_v_q <= 1'b1;
      else if (res_o.ready)  out_v_q <= 1'b0;

      if (s1_go) flags_q <= alu.flags;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) s1_insn_q <= insn_i.instruction_word;
    if (s1_go) begin
      s2_exec_q  <= alu.executed;
      s2_we_q    <= alu.we;
      s2_mul_q   <= alu.is_mul;
      s2_sub_q   <= alu.sub;
      s2_sf_q    <= alu.sf;
      s2_rd_q    <= s1_f.rd;
      s2_flags_q <= alu.flags;
      s2_res_q   <= alu.res;
      s2_pll_q   <= alu.pll;
      s2_plh_q   <= alu.plh;
      s2_phl_q   <= alu.phl;
    end
    if (out_load) begin
      out_exec_q  <= s2_exec_q;
      out_we_q    <= s2_we_q;
      out_rd_q    <= s2_rd_q;
      out_val_q   <= s2_we_q ? wdata : 64'd0;
      out_flags_q <= s2_flags_q;
    end
  end

  assign res_o.valid        = out_v_q;
  assign res_o.executed     = out_exec_q;
  assign res_o.write_enable = out_we_q;
  assign res_o.dest_index   = out_rd_q;
  assign res_o.write_value  = out_val_q;
  assign res_o.flag_n       = out_flags_q[3];
  assign res_o.flag_z       = out_flags_q[2];
  assign res_o.flag_c       = out_flags_q[1];
  assign res_o.flag_v       = out_flags_q[0];

  a_no_zr_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_wr.we |-> (rf_wr.addr != ZeroReg))
    else $error("register file write to the zero register");

  a_w_form_zext: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && !s2_sf_q) |-> (wdata[63:32] == 32'd0))
    else $error("32-bit form result not zero-extended");

  a_haz_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && mul_haz) |=> (s1_v_q && $stable(s1_insn_q)))
    else $error("word left stage 1 while its multiply operand was pending");

  a_noexec_nowrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.executed) |-> (!res_o.write_enable && res_o.write_value == 64'd0))
    else $error("unhandled word produced a register write");

endmodule
